// File: src/pcbd_pkg.sv
`timescale 1ns / 1ps
package pcbd_pkg;

	localparam int STEP_COUNT = 32;
	localparam int TABLE_ROWS = 21;
	localparam int TIMER_W    = 16;
	localparam int STEP_W     = 6;
	localparam int PULSE_W    = 5;
	localparam int LEVEL_W    = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_W      = 16;

	localparam logic [LEVEL_W-1:0] MIN_LEVEL = 8'd20;
	localparam logic [STEP_W-1:0]  DIM_STEP  = 6'd31;
	localparam logic [STEP_W-1:0]  BOOT_STEP = 6'd18;
	localparam logic [STEP_W-1:0]  FULL_STEP = 6'(STEP_COUNT);

	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_HOLD    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START       = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 8'd3;

	localparam logic [LEVEL_W-1:0] LVL_TOP [TABLE_ROWS] = '{
		8'd255, 8'd245, 8'd235, 8'd225, 8'd215, 8'd200, 8'd185, 8'd170, 8'd155, 8'd140,
		8'd125, 8'd110, 8'd95, 8'd80, 8'd70, 8'd60, 8'd50, 8'd40, 8'd30, 8'd20, 8'd0
	};
	localparam logic [STEP_W-1:0] LVL_STEP [TABLE_ROWS] = '{
		6'd3, 6'd5, 6'd7, 6'd9, 6'd11, 6'd13, 6'd15, 6'd16, 6'd17, 6'd18,
		6'd20, 6'd22, 6'd24, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd31, 6'd32
	};

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_OFF    = 6'b000010,
		PH_START  = 6'b000100,
		PH_LOW    = 6'b001000,
		PH_HIGH   = 6'b010000,
		PH_SETTLE = 6'b100000
	} phase_t;

	typedef struct packed {
		logic              line_level;
		logic              busy_res;
		logic              accepted;
		logic [STEP_W-1:0] chip_step;
	} result_t;

	function automatic logic [STEP_W-1:0] level_to_step(input logic [LEVEL_W-1:0] lv);
		logic [STEP_W-1:0] st;
		logic              hit;
		st  = '0;
		hit = 1'b0;
		if (lv == '0) begin
			st = '0;
		end else if (lv < MIN_LEVEL) begin
			st = DIM_STEP;
		end else begin
			for (int i = 0; i < TABLE_ROWS - 1; i++) begin
				if (!hit && lv <= LVL_TOP[i] && lv > LVL_TOP[i+1]) begin
					st  = LVL_STEP[i];
					hit = 1'b1;
				end
			end
		end
		return st;
	endfunction

endpackage

// File: src/pcbd_out_buf.sv
`timescale 1ns / 1ps
module pcbd_out_buf
	import pcbd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: src/pulse_count_backlight_dimmer.sv
`timescale 1ns / 1ps
// Each request is processed in the cycle it is accepted; its result is registered in the output buffer.
// Throughput is one request per cycle while the output buffer is not full (in_stall low).
// A two-entry output buffer takes one more request while a result waits downstream, then stalls the input.
// Reset is asynchronous and active low: the chip is taken as on at step 18, line high, idle,
// and the timing registers return to 3, 3000, 3 and 1000 ticks.
module pulse_count_backlight_dimmer
	import pcbd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [LEVEL_W-1:0]   level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 line_level,
	output logic                 busy_res,
	output logic                 accepted,
	output logic [STEP_W-1:0]    chip_step,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [TIMER_W-1:0] half_period_q;
	logic [TIMER_W-1:0] off_hold_q;
	logic [TIMER_W-1:0] start_q;
	logic [TIMER_W-1:0] settle_q;

	logic [STEP_W-1:0]  step_now_q;
	logic [STEP_W-1:0]  step_target_q;
	logic [PULSE_W-1:0] pulses_left_q;
	phase_t             phase_q;
	logic [TIMER_W-1:0] phase_timer_q;
	logic               line_q;

	logic [STEP_W-1:0]  nxt_step_now;
	logic [STEP_W-1:0]  nxt_target;
	logic [PULSE_W-1:0] nxt_pulses;
	phase_t             nxt_phase;
	logic [TIMER_W-1:0] nxt_timer;
	logic               nxt_line;
	logic               nxt_acc;
	logic               go_pulse;
	logic [STEP_W-1:0]  pulse_cur;
	logic               do_low;
	logic               do_finish;
	logic [STEP_W-1:0]  diff;

	logic    buf_full;
	logic    take;
	result_t res;
	result_t out_res;

	assign cfg_ready = 1'b1;
	assign in_stall  = buf_full;
	assign take      = in_valid && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= 16'd3;
			off_hold_q    <= 16'd3000;
			start_q       <= 16'd3;
			settle_q      <= 16'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HALF_PERIOD: half_period_q <= cfg_data;
				REG_OFF_HOLD:    off_hold_q    <= cfg_data;
				REG_START:       start_q       <= cfg_data;
				REG_SETTLE:      settle_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		nxt_step_now = step_now_q;
		nxt_target   = step_target_q;
		nxt_pulses   = pulses_left_q;
		nxt_phase    = phase_q;
		nxt_timer    = phase_timer_q;
		nxt_line     = line_q;
		nxt_acc      = 1'b0;
		go_pulse     = 1'b0;
		pulse_cur    = step_now_q;
		do_low       = 1'b0;
		do_finish    = 1'b0;
		diff         = '0;

		if (action) begin
			if (phase_q == PH_IDLE) begin
				nxt_acc    = 1'b1;
				nxt_target = level_to_step(level);
				if (nxt_target == '0) begin
					nxt_line  = 1'b0;
					nxt_phase = PH_OFF;
					nxt_timer = off_hold_q;
				end else if (step_now_q == '0) begin
					nxt_line  = 1'b1;
					nxt_phase = PH_START;
					nxt_timer = start_q;
				end else begin
					go_pulse = 1'b1;
				end
			end
		end else if (phase_q != PH_IDLE) begin
			if (phase_timer_q <= 16'd1) begin
				case (phase_q)
					PH_OFF: begin
						do_finish = 1'b1;
					end
					PH_START: begin
						nxt_step_now = FULL_STEP;
						pulse_cur    = FULL_STEP;
						go_pulse     = 1'b1;
					end
					PH_LOW: begin
						nxt_line  = 1'b1;
						nxt_phase = PH_HIGH;
						nxt_timer = half_period_q;
					end
					PH_HIGH: begin
						nxt_pulses = pulses_left_q - 5'd1;
						if (nxt_pulses != '0) begin
							do_low = 1'b1;
						end else begin
							do_finish = 1'b1;
						end
					end
					default: begin
						nxt_phase = PH_IDLE;
						nxt_timer = '0;
					end
				endcase
			end else begin
				nxt_timer = phase_timer_q - 16'd1;
			end
		end

		if (go_pulse) begin
			diff       = nxt_target - pulse_cur;
			nxt_pulses = diff[PULSE_W-1:0];
			if (nxt_pulses != '0) begin
				do_low = 1'b1;
			end else begin
				do_finish = 1'b1;
			end
		end

		if (do_low) begin
			nxt_line  = 1'b0;
			nxt_phase = PH_LOW;
			nxt_timer = half_period_q;
		end

		if (do_finish) begin
			nxt_step_now = nxt_target;
			if (settle_q == '0) begin
				nxt_phase = PH_IDLE;
				nxt_timer = '0;
			end else begin
				nxt_phase = PH_SETTLE;
				nxt_timer = settle_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_now_q    <= BOOT_STEP;
			step_target_q <= '0;
			pulses_left_q <= '0;
			phase_q       <= PH_IDLE;
			phase_timer_q <= '0;
			line_q        <= 1'b1;
		end else if (take) begin
			step_now_q    <= nxt_step_now;
			step_target_q <= nxt_target;
			pulses_left_q <= nxt_pulses;
			phase_q       <= nxt_phase;
			phase_timer_q <= nxt_timer;
			line_q        <= nxt_line;
		end
	end

	always_comb begin
		res.line_level = nxt_line;
		res.busy_res   = (nxt_phase != PH_IDLE);
		res.accepted   = nxt_acc;
		res.chip_step  = nxt_step_now;
	end

	pcbd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign line_level = out_res.line_level;
	assign busy_res   = out_res.busy_res;
	assign accepted   = out_res.accepted;
	assign chip_step  = out_res.chip_step;

endmodule
